FILE: hw/rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// shared types and constants of the frame rate meter
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int RATE_W   = 20;
    localparam int PERIOD_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0] RATE_SCALE = 20'd1000000;
    localparam logic [RATE_W-1:0] RATE_MAX   = 20'd999999;

    localparam logic [RATE_W-1:0] GOOD_RESET = 20'd60;
    localparam logic [RATE_W-1:0] FAIR_RESET = 20'd30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIR = 2'd1;

    // rating codes
    localparam logic [1:0] RATING_RED    = 2'd0;
    localparam logic [1:0] RATING_YELLOW = 2'd1;
    localparam logic [1:0] RATING_GREEN  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // transaction accepted, start rate division
        logic update;     // store rate, update ring, sum and fill count
        logic avg_start;  // start average division
        logic finish;     // load result registers
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

FILE: hw/rtl/frm_ram.sv
// ----------------------------------------------------------------------------
// frm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 20
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/frm_div.sv
// ----------------------------------------------------------------------------
// frm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module frm_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hw/rtl/frm_dpath.sv
// ----------------------------------------------------------------------------
// frm_dpath
// datapath: thresholds, rate ring, running sum, shared divider, result registers
// ----------------------------------------------------------------------------
module frm_dpath
    import frm_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATE_W-1:0]    i_cfg_wdata,
    input  logic [PERIOD_W-1:0]  i_frame_period_us,
    output logic [RATE_W-1:0]    o_instant_rate,
    output logic [RATE_W-1:0]    o_average_rate,
    output logic [1:0]           o_rating
);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = CNT_W + 1;
    localparam int SUM_W  = RATE_W + CNT_W;

    logic [RATE_W-1:0] r_good_thr;
    logic [RATE_W-1:0] r_fair_thr;
    logic [IDX_W-1:0]  r_oldest;
    logic [CNT_W-1:0]  r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic              r_zero;
    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_out_rate;
    logic [RATE_W-1:0] r_out_avg;
    logic [1:0]        r_out_rating;

    logic              div_start;
    logic [SUM_W-1:0]  div_num;
    logic [PERIOD_W-1:0] div_den;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;

    logic              full;
    logic [SLOT_W-1:0] slot_sum;
    logic [SLOT_W-1:0] next_sum;
    logic [IDX_W-1:0]  wslot;
    logic [IDX_W-1:0]  next_oldest;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] ram_rdata;
    logic [SUM_W-1:0]  drop;
    logic [RATE_W-1:0] avg;
    logic [1:0]        rating;

    // shared divider: rate first, average second
    always_comb begin
        div_start = i_cmd.load | i_cmd.avg_start;
        div_num   = i_cmd.load ? SUM_W'(RATE_SCALE) : r_sum;
        div_den   = i_cmd.load ? i_frame_period_us : PERIOD_W'(r_fill);
    end

    frm_div #(
        .NUM_W (SUM_W),
        .DEN_W (PERIOD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_sts.div_done = div_done;

    always_comb begin
        full     = r_fill == CNT_W'(WINDOW);
        slot_sum = SLOT_W'(r_oldest) + SLOT_W'(r_fill);
        wslot    = (slot_sum >= SLOT_W'(WINDOW)) ?
                   IDX_W'(slot_sum - SLOT_W'(WINDOW)) : IDX_W'(slot_sum);
        next_sum = SLOT_W'(r_oldest) + SLOT_W'(1);
        next_oldest = (next_sum >= SLOT_W'(WINDOW)) ?
                      IDX_W'(next_sum - SLOT_W'(WINDOW)) : IDX_W'(next_sum);
        if (full) begin
            wslot = r_oldest;
        end
        // saturate: a zero period, or a period of one (quotient 1000000), gives 999999
        if (r_zero || div_quo > SUM_W'(RATE_MAX)) begin
            rate = RATE_MAX;
        end else begin
            rate = div_quo[RATE_W-1:0];
        end
        drop = full ? SUM_W'(ram_rdata) : '0;
        avg  = div_quo[RATE_W-1:0];
        priority if (avg >= r_good_thr) begin
            rating = RATING_GREEN;
        end else if (avg >= r_fair_thr) begin
            rating = RATING_YELLOW;
        end else begin
            rating = RATING_RED;
        end
    end

    frm_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (wslot),
        .i_wdata (rate),
        .i_re    (i_cmd.load),
        .i_raddr (r_oldest),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_thr <= GOOD_RESET;
            r_fair_thr <= FAIR_RESET;
            r_oldest   <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GOOD) begin
                    r_good_thr <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_FAIR) begin
                    r_fair_thr <= i_cfg_wdata;
                end
            end
            if (i_cmd.update) begin
                r_sum <= r_sum - drop + SUM_W'(rate);
                if (full) begin
                    r_oldest <= next_oldest;
                end else begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= i_frame_period_us == '0;
        end
        if (i_cmd.update) begin
            r_rate <= rate;
        end
        if (i_cmd.finish) begin
            r_out_rate   <= r_rate;
            r_out_avg    <= avg;
            r_out_rating <= rating;
        end
    end

    assign o_instant_rate = r_out_rate;
    assign o_average_rate = r_out_avg;
    assign o_rating       = r_out_rating;

endmodule

FILE: hw/rtl/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl
// sequencer: accept, rate division, ring update, average division, result
// ----------------------------------------------------------------------------
module frm_ctrl
    import frm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_UPDATE,
        S_AVG_START,
        S_AVG,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RATE;
                end
            end
            S_RATE: begin
                if (i_sts.div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_AVG_START;
            end
            S_AVG_START: begin
                o_cmd.avg_start = 1'b1;
                n_state         = S_AVG;
            end
            S_AVG: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/frame_rate_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_meter
// moving-average frame rate meter with three-level rating
// ----------------------------------------------------------------------------
// Each input transaction carries one frame period in microseconds. The block
// works out the instantaneous rate as 1000000 / period (999999 for a period of
// zero or one), keeps the last WINDOW rates in a ring ram, and returns the
// floor of their mean together with a green / yellow / red rating against the
// two threshold registers (index 0 good, index 1 fair; the good threshold is
// tested first). One transaction is processed at a time, and the next
// transaction can be taken as soon as the result appears; both divisions go
// through one shared restoring divider that retires one quotient bit per
// cycle. The result sits in an output register, so the next transaction is
// taken while a finished result still waits; it stalls only at the very end
// if the previous result has still not been taken. No clearing pass is needed
// after reset. Thresholds should be written only while the block is idle.
// ----------------------------------------------------------------------------
module frame_rate_meter
    import frm_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATE_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PERIOD_W-1:0]  i_frame_period_us,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [RATE_W-1:0]    o_instant_rate,
    output logic [RATE_W-1:0]    o_average_rate,
    output logic [1:0]           o_rating
);
    t_cmd cmd;
    t_sts sts;

    // sequencer
    frm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // arithmetic, ring storage and result registers
    frm_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_frame_period_us (i_frame_period_us),
        .o_instant_rate    (o_instant_rate),
        .o_average_rate    (o_average_rate),
        .o_rating          (o_rating)
    );

endmodule

FILE: bench/frame_rate_meter_tb.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_tb
// self-checking bench for the moving-average frame rate meter
// ----------------------------------------------------------------------------
// A short table of directed transactions and threshold writes comes first.
// Random phases follow, each under its own pair of thresholds. The sender
// works in bursts and the receiver stalls in changing regimes. Every result
// is checked field by field against a behavioural model of the meter that is
// kept inside the bench, or against a result written out by hand in the table.
// ----------------------------------------------------------------------------
module frame_rate_meter_tb
    import frm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN   = 20;     // ring depth of the instance below
    localparam int DRAIN_CYCLES = 64;     // a little more than one transaction's latency
    localparam int N_DIRECTED   = 24;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 125;

    // indexes that decode to no register, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [RATE_W-1:0] instant;
        logic [RATE_W-1:0] average;
        logic [1:0]        rating;
    } t_meter_result;

    typedef enum logic {ROW_TRANSACTION, ROW_REG_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [RATE_W-1:0]     wdata;
        logic [PERIOD_W-1:0]   period;
        logic                  typed;    // result below is written out by hand
        t_meter_result         result;
    } t_directed_row;

    typedef enum logic [1:0] {RX_FREE, RX_JITTER, RX_BLOCKING} t_rx_mode;

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [RATE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [PERIOD_W-1:0]  i_frame_period_us = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [RATE_W-1:0]    o_instant_rate;
    logic [RATE_W-1:0]    o_average_rate;
    logic [1:0]           o_rating;

    frame_rate_meter #(
        .WINDOW (WINDOW_LEN)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_frame_period_us (i_frame_period_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_instant_rate    (o_instant_rate),
        .o_average_rate    (o_average_rate),
        .o_rating          (o_rating)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench copy of the meter state and thresholds
    // ------------------------------------------------------------------------
    logic [RATE_W-1:0] hist_ring [WINDOW_LEN];
    logic [4:0]        hist_oldest = '0;
    logic [4:0]        hist_fill = '0;
    logic [24:0]       hist_sum = '0;
    logic [RATE_W-1:0] thr_good = GOOD_RESET;
    logic [RATE_W-1:0] thr_fair = FAIR_RESET;

    t_meter_result result_q [$];   // results still owed by the dut, oldest first
    int            fail_count = 0;
    int            burst_left = 0;

    // directed table: extremes of the period, saturation, every rating and
    // threshold order, writes to unused indexes
    t_directed_row directed_rows [N_DIRECTED] = '{
        // period zero and one both saturate
        '{ROW_TRANSACTION, '0, '0, 32'd0, 1'b1, '{RATE_MAX, RATE_MAX, RATING_GREEN}},
        '{ROW_TRANSACTION, '0, '0, 32'd1, 1'b1, '{RATE_MAX, RATE_MAX, RATING_GREEN}},
        // longest period gives a zero rate
        '{ROW_TRANSACTION, '0, '0, 32'hFFFF_FFFF, 1'b1, '{20'd0, 20'd666666, RATING_GREEN}},
        '{ROW_TRANSACTION, '0, '0, 32'd1000000, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd1000001, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd2, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd3, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd999999, 1'b0, '0},
        // both thresholds at zero, all green
        '{ROW_REG_WRITE, CFG_GOOD, 20'd0, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_FAIR, 20'd0, '0, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd16666, 1'b0, '0},
        // both at the top
        '{ROW_REG_WRITE, CFG_GOOD, 20'd999999, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_FAIR, 20'd999999, '0, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd500000, 1'b0, '0},
        // fair above good, good is tested first
        '{ROW_REG_WRITE, CFG_GOOD, 20'd0, '0, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd7, 1'b0, '0},
        // wide yellow band
        '{ROW_REG_WRITE, CFG_GOOD, 20'd999999, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_FAIR, 20'd0, '0, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd33333, 1'b0, '0},
        // back to reset values, then writes that must change nothing
        '{ROW_REG_WRITE, CFG_GOOD, GOOD_RESET, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_FAIR, FAIR_RESET, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_SPARE_A, 20'hFFFFF, '0, 1'b0, '0},
        '{ROW_REG_WRITE, CFG_SPARE_B, 20'h00000, '0, 1'b0, '0},
        '{ROW_TRANSACTION, '0, '0, 32'd16667, 1'b0, '0}
    };

    // instantaneous rate, saturated to the field range
    function automatic logic [RATE_W-1:0] frame_rate(input logic [PERIOD_W-1:0] period);
        logic [PERIOD_W-1:0] quotient;
        if (period == '0) return RATE_MAX;
        quotient = PERIOD_W'(RATE_SCALE) / period;
        if (quotient > PERIOD_W'(RATE_MAX)) return RATE_MAX;
        return quotient[RATE_W-1:0];
    endfunction

    // store one rate in the window and work out the result it produces
    function automatic t_meter_result advance_meter(input logic [PERIOD_W-1:0] period);
        t_meter_result     res;
        logic [RATE_W-1:0] rate;
        logic [5:0]        slot;
        logic [24:0]       mean;
        rate = frame_rate(period);
        if (hist_fill < 5'(WINDOW_LEN)) begin
            // still filling: append behind the newest entry
            slot = 6'(hist_oldest) + 6'(hist_fill);
            if (slot >= 6'(WINDOW_LEN)) slot = slot - 6'(WINDOW_LEN);
            hist_ring[slot[4:0]] = rate;
            hist_fill = hist_fill + 5'd1;
            hist_sum = hist_sum + 25'(rate);
        end else begin
            // full: the oldest rate makes room for the new one
            hist_sum = hist_sum - 25'(hist_ring[hist_oldest]) + 25'(rate);
            hist_ring[hist_oldest] = rate;
            hist_oldest = (hist_oldest == 5'(WINDOW_LEN - 1)) ? '0 : hist_oldest + 5'd1;
        end
        mean = hist_sum / 25'(hist_fill);
        res.instant = rate;
        res.average = mean[RATE_W-1:0];
        if (res.average >= thr_good) res.rating = RATING_GREEN;
        else if (res.average >= thr_fair) res.rating = RATING_YELLOW;
        else res.rating = RATING_RED;
        return res;
    endfunction

    // one register write, only ever issued while the meter is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_GOOD: thr_good = data;
            CFG_FAIR: thr_fair = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one period, wait for the transaction, then maybe pause
    task automatic send_period(input logic [PERIOD_W-1:0] period, input logic typed,
                               input t_meter_result typed_res);
        t_meter_result predicted;
        int            gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_frame_period_us <= period;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_meter(period);
        result_q.insert(result_q.size(), typed ? typed_res : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: a gap that lands anywhere in the divider's work
            burst_left = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3, 4, 5, 6, 7: gap = $urandom_range(1, 60);
                default: gap = $urandom_range(60, 100);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // stop sending and wait until every owed result has been taken
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: stall pattern switches between free, jittery and blocking
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_stall_left = 0;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(200, 1200);
        end else begin
            rx_mode_left--;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            case (rx_mode)
                RX_JITTER: if ($urandom_range(0, 9) < 3) rx_stall_left = $urandom_range(1, 4);
                RX_BLOCKING: if ($urandom_range(0, 99) < 4) rx_stall_left = $urandom_range(20, 120);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checker, runs on every output transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_meter_result got;
        t_meter_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_instant_rate, o_average_rate, o_rating};
            if (result_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: instant %0d average %0d rating %0d",
                             got.instant, got.average, got.rating);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: instant %0d/%0d average %0d/%0d rating %0d/%0d",
                                 want.instant, got.instant, want.average, got.average,
                                 want.rating, got.rating);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] last_period;
        logic [RATE_W-1:0]   mean_now;
        int                  pick;
        last_period = 32'd16667;

        // hold the synchronous reset at the start, then release it
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_REG_WRITE) begin
                drain();
                write_reg(directed_rows[r].idx, directed_rows[r].wdata);
            end else begin
                send_period(directed_rows[r].period, directed_rows[r].typed,
                            directed_rows[r].result);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    // anything in range, order may come out reversed
                    write_reg(CFG_GOOD, RATE_W'($urandom_range(0, 999999)));
                    write_reg(CFG_FAIR, RATE_W'($urandom_range(0, 999999)));
                end
                1: begin
                    write_reg(CFG_GOOD, RATE_MAX);
                    write_reg(CFG_FAIR, 20'd0);
                end
                2: begin
                    // thresholds on the current mean so that steady frames hit equality
                    mean_now = (hist_fill == '0) ? '0 : RATE_W'(hist_sum / 25'(hist_fill));
                    write_reg(CFG_GOOD, mean_now);
                    write_reg(CFG_FAIR, (mean_now > 20'd5) ? mean_now - 20'd5 : '0);
                end
                3: begin
                    write_reg(CFG_GOOD, 20'd0);
                    write_reg(CFG_FAIR, RATE_MAX);
                end
                4: begin
                    // bands a real display would use
                    write_reg(CFG_GOOD, RATE_W'($urandom_range(40, 200)));
                    write_reg(CFG_FAIR, RATE_W'($urandom_range(10, 60)));
                end
                default: begin
                    write_reg(CFG_GOOD, GOOD_RESET);
                    write_reg(CFG_FAIR, FAIR_RESET);
                end
            endcase
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          RATE_W'($urandom_range(0, 20'hFFFFF)));

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      period = $urandom_range(3000, 60000);   // typical frame times
                else if (pick < 55) period = last_period;                   // steady frames
                else if (pick < 65) period = $urandom_range(0, 16);         // saturation region
                else if (pick < 75) period = $urandom_range(999990, 1000010);
                else if (pick < 90) period = $urandom();                    // full field range
                else                period = $urandom_range(1, 3000);
                send_period(period, 1'b0, '0);
                last_period = period;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/frm_pkg.sv
hw/rtl/frm_ram.sv
hw/rtl/frm_div.sv
hw/rtl/frm_dpath.sv
hw/rtl/frm_ctrl.sv
hw/rtl/frame_rate_meter.sv
bench/frame_rate_meter_tb.sv
